// ===== design/sgb_pkg.sv =====
// Shared types and constants for the separable blur block.
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

    localparam int PIX_W        = 24;
    localparam int TAP_W        = 15;
    localparam int CFG_W        = 60;
    localparam int CFG_IDX_W    = 3;
    localparam int SIZE_W       = 9;
    localparam int NUM_REG_TAPS = 11;
    localparam int TAPS_PER_REG = 4;
    localparam int TAP_CAT_W    = 165;
    localparam int ROUND_SHIFT  = 14;
    localparam logic [PIX_W-1:0] PIX_MAX = 24'hFFFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE  = 3'd0,
        REG_HTAPS_LOW   = 3'd1,
        REG_HTAPS_MID   = 3'd2,
        REG_HTAPS_HIGH  = 3'd3,
        REG_VTAPS_LOW   = 3'd4,
        REG_VTAPS_MID   = 3'd5,
        REG_VTAPS_HIGH  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/separable_gaussian_blur.sv =====
// Top level of the streaming separable 2D convolution with zero padding.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------
//  input    | i_valid / o_stall | i_in  (action, pixel_in)
//  output   | o_valid / i_stall | o_out (pixel_out, last_out)
//  config   | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// One request is taken every cycle while the output is not stalled; a result is registered
// behind five register stages: products and sum of the horizontal pass,
// the line buffer read, and products and sum of the vertical pass.
// The frame delay is MAX_RADIUS*size+MAX_RADIUS requests, drained by flushes.
// Reset is synchronous and active low; the line buffers need no clearing.
// A stall on the output holds the whole pipeline while a result is waiting, and o_stall follows it.
`timescale 1ns / 1ps
`default_nettype none

module separable_gaussian_blur
    import sgb_pkg::*;
#(
    parameter int MAX_SIZE   = 256,
    parameter int MAX_RADIUS = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_item             i_in,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int LINES  = 2 * MAX_RADIUS;
    localparam int CW     = $clog2(MAX_SIZE);
    localparam int NW     = $clog2(MAX_SIZE + 1);
    localparam int RW     = $clog2(MAX_SIZE + 2 * MAX_RADIUS + 2);
    localparam int LW     = $clog2(LINES);
    localparam int PW     = $clog2(MAX_RADIUS + 1);
    localparam int PROD_W = PIX_W + TAP_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    typedef struct packed {
        logic            wr;
        logic            emit;
        logic            last;
        logic [CW-1:0]   col;
        logic [LW-1:0]   line;
        logic [TAPS-1:0] vmask;
    } t_ctrl;

    function automatic logic [PIX_W-1:0] f_round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] r;
        r = ({1'b0, acc} + (ACC_W + 1)'(1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        f_round_sat = (r > (ACC_W + 1)'(PIX_MAX)) ? PIX_MAX : r[PIX_W-1:0];
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] r_image_size;
    logic [CFG_W-1:0]  r_h_low, r_h_mid, r_v_low, r_v_mid;
    logic [44:0]       r_h_high, r_v_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= SIZE_W'(64);
            r_h_low      <= '0;
            r_h_mid      <= CFG_W'(536870912);
            r_h_high     <= '0;
            r_v_low      <= '0;
            r_v_mid      <= CFG_W'(536870912);
            r_v_high     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_SIZE: r_image_size <= i_cfg_data[SIZE_W-1:0];
                REG_HTAPS_LOW:  r_h_low      <= i_cfg_data;
                REG_HTAPS_MID:  r_h_mid      <= i_cfg_data;
                REG_HTAPS_HIGH: r_h_high     <= i_cfg_data[44:0];
                REG_VTAPS_LOW:  r_v_low      <= i_cfg_data;
                REG_VTAPS_MID:  r_v_mid      <= i_cfg_data;
                REG_VTAPS_HIGH: r_v_high     <= i_cfg_data[44:0];
                default: ;
            endcase
        end
    end

    // Unpack the taps; taps beyond the register set read as zero.
    logic [TAP_CAT_W-1:0] w_hcat, w_vcat;
    logic [TAP_W-1:0]     w_htap [TAPS];
    logic [TAP_W-1:0]     w_vtap [TAPS];

    assign w_hcat = {r_h_high, r_h_mid, r_h_low};
    assign w_vcat = {r_v_high, r_v_mid, r_v_low};

    for (genvar j = 0; j < TAPS; j++) begin : g_taps
        if (j < NUM_REG_TAPS) begin : g_reg
            assign w_htap[j] = w_hcat[TAP_W*j +: TAP_W];
            assign w_vtap[j] = w_vcat[TAP_W*j +: TAP_W];
        end else begin : g_zero
            assign w_htap[j] = '0;
            assign w_vtap[j] = '0;
        end
    end

    // Pipeline advance: everything moves unless a finished result is held.
    logic w_adv;
    logic r_ov;
    assign w_adv   = !r_ov || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_ov;

    // Stream position state.
    logic             r_busy;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PW-1:0]    r_pre;
    logic [NW-1:0]    r_hcol;
    logic [RW-1:0]    r_hrow;
    logic [LW-1:0]    r_hline;
    logic [PIX_W-1:0] r_win [LINES];

    logic [NW-1:0]    w_n;
    logic             w_in_frame, w_eff, w_hv, w_emit, w_last, w_wr;
    logic [PIX_W-1:0] w_v;
    logic [PIX_W-1:0] w_win [TAPS];
    logic [31:0]      w_size;

    // Frame size is latched from the register when a frame starts.
    always_comb begin
        w_size = 32'(r_image_size);
        if (w_size == 32'd0) begin
            w_n = NW'(1);
        end else if (w_size > 32'(MAX_SIZE)) begin
            w_n = NW'(MAX_SIZE);
        end else begin
            w_n = NW'(w_size);
        end
        if (r_busy) begin
            w_n = r_n;
        end
    end

    // Classify the request: flushes while idle or inside the frame are dropped.
    assign w_in_frame = !r_busy || (32'(r_row) < 32'(r_n));
    assign w_eff  = i_valid && w_adv && !(i_in.action && w_in_frame);
    assign w_v    = (w_in_frame && !i_in.action) ? i_in.pixel_in : '0;
    assign w_hv   = (32'(r_pre) == 32'(MAX_RADIUS));
    assign w_emit = w_hv && (32'(r_hrow) >= 32'(MAX_RADIUS))
                    && (32'(r_hrow) < 32'(w_n) + 32'(MAX_RADIUS));
    assign w_last = w_emit && (32'(r_hrow) == 32'(w_n) + 32'(MAX_RADIUS) - 32'd1)
                    && (32'(r_hcol) == 32'(w_n) - 32'd1);
    assign w_wr   = w_hv && (32'(r_hrow) < 32'(w_n));

    // Shifted row window; a new frame starts from an empty window.
    always_comb begin
        w_win[0] = w_v;
        for (int i = 1; i < TAPS; i++) begin
            w_win[i] = r_busy ? r_win[i-1] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_n     <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pre   <= '0;
            r_hcol  <= '0;
            r_hrow  <= '0;
            r_hline <= '0;
        end else if (w_eff) begin
            if (w_last) begin
                r_busy  <= 1'b0;
                r_col   <= '0;
                r_row   <= '0;
                r_pre   <= '0;
                r_hcol  <= '0;
                r_hrow  <= '0;
                r_hline <= '0;
            end else begin
                r_busy <= 1'b1;
                r_n    <= w_n;
                if (32'(r_col) + 32'd1 >= 32'(w_n)) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + NW'(1);
                end
                if (!w_hv) begin
                    r_pre <= r_pre + PW'(1);
                end else if (32'(r_hcol) + 32'd1 >= 32'(w_n)) begin
                    r_hcol  <= '0;
                    r_hrow  <= r_hrow + RW'(1);
                    r_hline <= (32'(r_hline) == LINES - 1) ? '0 : r_hline + LW'(1);
                end else begin
                    r_hcol <= r_hcol + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eff) begin
            for (int i = 0; i < LINES; i++) begin
                r_win[i] <= w_win[i];
            end
        end
    end

    // Stage 1: horizontal products, masked at the row edges.
    logic              r_s1_v;
    t_ctrl             r_s1_c;
    logic [PROD_W-1:0] r_s1_prod [TAPS];
    t_ctrl             w_c0;

    always_comb begin
        w_c0.wr    = w_wr;
        w_c0.emit  = w_emit;
        w_c0.last  = w_last;
        w_c0.col   = r_hcol[CW-1:0];
        w_c0.line  = r_hline;
        for (int j = 0; j < TAPS; j++) begin
            w_c0.vmask[j] = (32'(r_hrow) + 32'(j) >= 32'(2 * MAX_RADIUS))
                && (32'(r_hrow) + 32'(j) < 32'(w_n) + 32'(2 * MAX_RADIUS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_eff && w_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_c <= w_c0;
            for (int j = 0; j < TAPS; j++) begin
                if ((32'(r_hcol) + 32'(j) >= 32'(MAX_RADIUS))
                    && (32'(r_hcol) + 32'(j) < 32'(w_n) + 32'(MAX_RADIUS))) begin
                    r_s1_prod[j] <= PROD_W'(w_win[2*MAX_RADIUS-j]) * PROD_W'(w_htap[j]);
                end else begin
                    r_s1_prod[j] <= '0;
                end
            end
        end
    end

    // Stage 2: horizontal sum, round and saturate.
    logic             r_s2_v;
    t_ctrl            r_s2_c;
    logic [PIX_W-1:0] r_s2_hval;
    logic [ACC_W-1:0] w_hsum;

    always_comb begin
        w_hsum = '0;
        for (int j = 0; j < TAPS; j++) begin
            w_hsum = w_hsum + ACC_W'(r_s1_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_c    <= r_s1_c;
            r_s2_hval <= f_round_sat(w_hsum);
        end
    end

    // Stage 3: write the row-filtered value and read the column from every line.
    logic             r_s3_v;
    t_ctrl            r_s3_c;
    logic [PIX_W-1:0] r_s3_hval;
    logic [PIX_W-1:0] w_rdata [LINES];

    sgb_line_mem #(
        .LINES (LINES),
        .DEPTH (MAX_SIZE),
        .CW    (CW),
        .LW    (LW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_en    (w_adv && r_s2_v),
        .i_wr    (r_s2_c.wr),
        .i_wline (r_s2_c.line),
        .i_col   (r_s2_c.col),
        .i_wdata (r_s2_hval),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_c    <= r_s2_c;
            r_s3_hval <= r_s2_hval;
        end
    end

    // Stage 4: vertical products; the newest row comes straight from the pass.
    logic              r_s4_v;
    logic              r_s4_last;
    logic [PROD_W-1:0] r_s4_prod [TAPS];
    logic [PIX_W-1:0]  w_vval [TAPS];

    always_comb begin
        logic [LW:0] sel;
        sel = '0;
        for (int j = 0; j < LINES; j++) begin
            sel = (LW + 1)'(r_s3_c.line) + (LW + 1)'(j);
            if (32'(sel) >= LINES) begin
                sel = sel - (LW + 1)'(LINES);
            end
            w_vval[j] = w_rdata[sel[LW-1:0]];
        end
        w_vval[TAPS-1] = r_s3_hval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_adv) begin
            r_s4_v <= r_s3_v && r_s3_c.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_last <= r_s3_c.last;
            for (int j = 0; j < TAPS; j++) begin
                r_s4_prod[j] <= r_s3_c.vmask[j]
                    ? PROD_W'(w_vval[j]) * PROD_W'(w_vtap[j]) : '0;
            end
        end
    end

    // Stage 5: vertical sum into the result register.
    logic [ACC_W-1:0] w_vsum;

    always_comb begin
        w_vsum = '0;
        for (int j = 0; j < TAPS; j++) begin
            w_vsum = w_vsum + ACC_W'(r_s4_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out.pixel_out <= f_round_sat(w_vsum);
            o_out.last_out  <= r_s4_last;
        end
    end

    // The pipeline only holds when a result is waiting downstream.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_ov)
        else $error("input stalled with no result waiting");

    // A flush while idle must not start a frame.
    a_idle_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_in.action && !r_busy) |=> !r_busy)
        else $error("flush started a frame");

    // Line buffer writes stay inside the line set.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (32'(r_s2_c.line) < LINES))
        else $error("line index out of range");

endmodule

`default_nettype wire

// ===== design/sgb_line_mem.sv =====
// Line buffer of row-filtered values: one memory per line, all read at one column.
`timescale 1ns / 1ps
`default_nettype none

module sgb_line_mem
    import sgb_pkg::*;
#(
    parameter int LINES = 10,
    parameter int DEPTH = 256,
    parameter int CW    = 8,
    parameter int LW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_wr,
    input  wire logic [LW-1:0]    i_wline,
    input  wire logic [CW-1:0]    i_col,
    input  wire logic [PIX_W-1:0] i_wdata,
    output logic      [PIX_W-1:0] o_rdata [LINES]
);

    for (genvar l = 0; l < LINES; l++) begin : g_line
        logic [PIX_W-1:0] r_mem [DEPTH];

        // The read returns the old entry when the same column is written.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_rdata[l] <= r_mem[i_col];
                if (i_wr && (i_wline == LW'(l))) begin
                    r_mem[i_col] <= i_wdata;
                end
            end
        end
    end

endmodule

`default_nettype wire
